// File: rtl/ofmq_pkg.sv
`default_nettype none
package ofmq_pkg;

	localparam int CFG_W        = 5;
	localparam int VAL_W        = 16;
	localparam int FILL_W       = 5;
	localparam int DEPTH_DEF    = 16;
	localparam int DATA_W_DEF   = 16;
	localparam logic [CFG_W-1:0] CAP_RESET = CFG_W'(16);
	localparam logic signed [VAL_W-1:0] EMPTY_VALUE = -VAL_W'(1);

	typedef enum logic [1:0] {
		CMD_PUSH = 2'd0,
		CMD_POP  = 2'd1,
		CMD_MIN  = 2'd2
	} cmd_t;

	typedef struct packed {
		logic [1:0]              command;
		logic signed [VAL_W-1:0] value_in;
	} in_item_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] value_out;
		logic                    was_empty;
		logic                    dropped_oldest;
		logic [FILL_W-1:0]       fill_count;
	} out_item_t;

	typedef struct packed {
		logic shift_en;
		logic load_en;
		logic in_use;
	} cell_ctrl_t;

endpackage
`default_nettype wire

// File: rtl/ofmq_cell.sv
`default_nettype none
module ofmq_cell #(
	parameter int DATA_WIDTH = 16
) (
	input  wire                           clk,
	input  wire ofmq_pkg::cell_ctrl_t     ctrl,
	input  wire logic signed [DATA_WIDTH-1:0] load_data,
	input  wire logic signed [DATA_WIDTH-1:0] next_data,
	input  wire logic signed [DATA_WIDTH-1:0] min_in,
	output logic signed [DATA_WIDTH-1:0]      data,
	output logic signed [DATA_WIDTH-1:0]      min_out
);
	import ofmq_pkg::*;

	logic signed [DATA_WIDTH-1:0] data_q;
	logic signed [DATA_WIDTH-1:0] min_q;
	logic signed [DATA_WIDTH-1:0] min_next;

	// pass the running minimum on, folding in this entry when it is stored
	assign min_next = (ctrl.in_use && (data_q < min_in)) ? data_q : min_in;

	always_ff @(posedge clk) begin
		if (ctrl.load_en) begin
			data_q <= load_data;
		end else if (ctrl.shift_en) begin
			data_q <= next_data;
		end
		min_q <= min_next;
	end

	assign data    = data_q;
	assign min_out = min_q;

endmodule
`default_nettype wire

// File: rtl/overwrite_fifo_with_min_query_unit.sv
`default_nettype none
// Channel    | Signals                          | Handshake
// command    | start, cmd                       | accepted when start && !busy
// result     | done, res                        | one result per item, no stall
// config     | cfg_valid, cfg_ready, cfg_data   | written when cfg_valid && cfg_ready
//
// Cell 0 holds the oldest entry; pop and overwrite shift the row toward cell 0.
// Push, pop, unknown commands and Min on an empty queue leave busy low: done
// rises in the cycle after accept, so such items can follow back to back.
// Min on a non-empty queue sends a running minimum down the row of DEPTH cells;
// busy stays high while the scan runs, and done rises in the cycle busy falls.
// Reset clears fill count and scan control and sets capacity to its default;
// cell contents are undefined.
// The result receiver cannot stall; each result is shown for one cycle.
module overwrite_fifo_with_min_query_unit #(
	parameter int DEPTH      = ofmq_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = ofmq_pkg::DATA_W_DEF
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           start,
	output logic                          busy,
	input  wire ofmq_pkg::in_item_t       cmd,
	output logic                          done,
	output ofmq_pkg::out_item_t           res,
	input  wire                           cfg_valid,
	output logic                          cfg_ready,
	input  wire [ofmq_pkg::CFG_W-1:0]     cfg_data
);
	import ofmq_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);
	localparam int XW = (CW > CFG_W) ? CW : CFG_W;
	localparam logic signed [DATA_WIDTH-1:0] MAX_VAL = {1'b0, {(DATA_WIDTH-1){1'b1}}};

	logic [CFG_W-1:0] cap_q;
	logic [CW-1:0]    count_q;
	logic [CW-1:0]    count_next;
	logic [CW-1:0]    cnt_q;
	logic             scan_q;
	logic             done_q;
	out_item_t        res_q;
	out_item_t        res_next;
	logic             accept;
	logic             cfg_wr;
	logic [XW-1:0]    cap_ext;
	logic [CW-1:0]    cap_eff;
	logic             full;
	logic             is_empty;
	logic             do_shift;
	logic             push_new;
	logic             push_over;
	logic             start_scan;
	logic signed [DATA_WIDTH-1:0] push_data;

	cell_ctrl_t                   ctrl [DEPTH];
	logic signed [DATA_WIDTH-1:0] cell_data [DEPTH];
	logic signed [DATA_WIDTH-1:0] cell_min  [DEPTH];

	assign busy      = scan_q;
	assign cfg_ready = !scan_q;
	assign accept    = start && !scan_q;
	assign cfg_wr    = cfg_valid && cfg_ready;

	// clamp capacity into 1..DEPTH
	always_comb begin
		cap_ext = XW'(cap_q);
		if (cap_ext == '0) begin
			cap_eff = CW'(1);
		end else if (cap_ext > XW'(DEPTH)) begin
			cap_eff = CW'(DEPTH);
		end else begin
			cap_eff = CW'(cap_ext);
		end
	end

	assign full      = (count_q >= cap_eff);
	assign is_empty  = (count_q == '0);
	assign push_data = DATA_WIDTH'(cmd.value_in);

	always_comb begin
		push_new   = 1'b0;
		push_over  = 1'b0;
		do_shift   = 1'b0;
		start_scan = 1'b0;
		count_next = count_q;
		res_next   = '0;
		res_next.fill_count = FILL_W'(count_q);
		if (accept) begin
			case (cmd.command)
				CMD_PUSH: begin
					if (full) begin
						push_over = 1'b1;
						do_shift  = 1'b1;
						res_next.dropped_oldest = 1'b1;
					end else begin
						push_new   = 1'b1;
						count_next = count_q + CW'(1);
					end
				end
				CMD_POP: begin
					if (is_empty) begin
						res_next.value_out = EMPTY_VALUE;
						res_next.was_empty = 1'b1;
					end else begin
						do_shift = 1'b1;
						count_next = count_q - CW'(1);
						res_next.value_out = VAL_W'(cell_data[0]);
					end
				end
				CMD_MIN: begin
					if (is_empty) begin
						res_next.value_out = EMPTY_VALUE;
						res_next.was_empty = 1'b1;
					end else begin
						start_scan = 1'b1;
					end
				end
				default: begin
				end
			endcase
			res_next.fill_count = FILL_W'(count_next);
		end
	end

	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			always_comb begin
				ctrl[gi].shift_en = do_shift;
				ctrl[gi].load_en  = (push_new && (count_q == CW'(gi))) ||
				                    (push_over && ((cap_eff - CW'(1)) == CW'(gi)));
				ctrl[gi].in_use   = (CW'(gi) < count_q);
			end

			if (gi == 0) begin : g_first
				ofmq_cell #(.DATA_WIDTH(DATA_WIDTH)) u_cell (
					.clk       (clk),
					.ctrl      (ctrl[gi]),
					.load_data (push_data),
					.next_data ((DEPTH > 1) ? cell_data[(DEPTH > 1) ? 1 : 0] : cell_data[0]),
					.min_in    (MAX_VAL),
					.data      (cell_data[gi]),
					.min_out   (cell_min[gi])
				);
			end else if (gi == DEPTH - 1) begin : g_last
				ofmq_cell #(.DATA_WIDTH(DATA_WIDTH)) u_cell (
					.clk       (clk),
					.ctrl      (ctrl[gi]),
					.load_data (push_data),
					.next_data (cell_data[gi]),
					.min_in    (cell_min[gi-1]),
					.data      (cell_data[gi]),
					.min_out   (cell_min[gi])
				);
			end else begin : g_mid
				ofmq_cell #(.DATA_WIDTH(DATA_WIDTH)) u_cell (
					.clk       (clk),
					.ctrl      (ctrl[gi]),
					.load_data (push_data),
					.next_data (cell_data[gi+1]),
					.min_in    (cell_min[gi-1]),
					.data      (cell_data[gi]),
					.min_out   (cell_min[gi])
				);
			end
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q   <= CAP_RESET;
			count_q <= '0;
			scan_q  <= 1'b0;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_wr) begin
				// a new capacity empties the queue
				cap_q   <= cfg_data;
				count_q <= '0;
			end else begin
				count_q <= count_next;
			end
			if (accept && !start_scan) begin
				done_q <= 1'b1;
			end
			if (start_scan) begin
				scan_q <= 1'b1;
				cnt_q  <= '0;
			end else if (scan_q) begin
				if (cnt_q == CW'(DEPTH)) begin
					scan_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (scan_q && (cnt_q == CW'(DEPTH))) begin
			res_q.value_out      <= VAL_W'(cell_min[DEPTH-1]);
			res_q.was_empty      <= 1'b0;
			res_q.dropped_oldest <= 1'b0;
			res_q.fill_count     <= FILL_W'(count_q);
		end else if (accept) begin
			res_q <= res_next;
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule
`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 100ps
module testbench;
	import ofmq_pkg::*;

	localparam logic [1:0] CMD_UNKNOWN = 2'd3;
	localparam int RING_DEPTH = 16;
	localparam int CYCLE_LIMIT = 300000;
	localparam int PHASE_ITEMS = 100;

	typedef struct {
		int        cfg;
		in_item_t  item;
		bit        typed;
		out_item_t want;
	} dir_row_t;

	logic      clk;
	logic      arst_n;
	logic      start;
	logic      busy;
	in_item_t  cmd;
	logic      done;
	out_item_t res;
	logic      cfg_valid;
	logic      cfg_ready;
	logic [CFG_W-1:0] cfg_data;

	// predictor state
	logic signed [VAL_W-1:0] ring [RING_DEPTH];
	logic [3:0]       rd_pos;
	logic [3:0]       wr_pos;
	logic [4:0]       fill;
	logic [CFG_W-1:0] cap_reg;

	out_item_t pending_results [$];
	int        mismatch_count;
	int        cycles;
	int        calm_left;
	dir_row_t  dir_tab [25];

	overwrite_fifo_with_min_query_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.done      (done),
		.res       (res),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #4 clk = ~clk;

	function automatic logic [3:0] next_pos(input logic [3:0] p, input logic [4:0] cap);
		logic [4:0] n;
		n = 5'(p) + 5'd1;
		return (n >= cap) ? 4'd0 : n[3:0];
	endfunction

	function automatic out_item_t predict_response(input in_item_t it);
		out_item_t r;
		logic [4:0] cap;
		logic [3:0] pos;
		r = '0;
		cap = (cap_reg == 0) ? 5'd1 : ((cap_reg > RING_DEPTH) ? 5'(RING_DEPTH) : cap_reg);
		case (it.command)
			CMD_PUSH: begin
				if (fill >= cap) begin
					rd_pos = next_pos(rd_pos, cap);
					r.dropped_oldest = 1'b1;
				end else begin
					fill = fill + 5'd1;
				end
				ring[wr_pos] = it.value_in;
				wr_pos = next_pos(wr_pos, cap);
			end
			CMD_POP: begin
				if (fill == 0) begin
					r.value_out = EMPTY_VALUE;
					r.was_empty = 1'b1;
				end else begin
					r.value_out = ring[rd_pos];
					rd_pos = next_pos(rd_pos, cap);
					fill = fill - 5'd1;
				end
			end
			CMD_MIN: begin
				if (fill == 0) begin
					r.value_out = EMPTY_VALUE;
					r.was_empty = 1'b1;
				end else begin
					pos = rd_pos;
					r.value_out = ring[pos];
					for (int i = 1; i < fill; i++) begin
						pos = next_pos(pos, cap);
						if (ring[pos] < r.value_out)
							r.value_out = ring[pos];
					end
				end
			end
			default: ;
		endcase
		r.fill_count = fill;
		return r;
	endfunction

	function automatic dir_row_t mk_row(input int cfg, input logic [1:0] c, input int v,
			input bit typed, input int vo, input bit e, input bit d, input int f);
		dir_row_t r;
		r.cfg = cfg;
		r.item.command = c;
		r.item.value_in = 16'(v);
		r.typed = typed;
		r.want.value_out = 16'(vo);
		r.want.was_empty = e;
		r.want.dropped_oldest = d;
		r.want.fill_count = 5'(f);
		return r;
	endfunction

	// called at a falling edge; returns at the falling edge after accept
	task automatic issue_cmd(input in_item_t it, input int gap, input bit typed,
			input out_item_t want);
		out_item_t p;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		cmd <= it;
		do @(posedge clk); while (busy);
		p = predict_response(it);
		pending_results.push_back(typed ? want : p);
		@(negedge clk);
	endtask

	task automatic drain_results;
		start <= 1'b0;
		@(negedge clk);
		while (pending_results.size() > 0 || busy)
			@(negedge clk);
	endtask

	task automatic write_capacity(input logic [CFG_W-1:0] v);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cap_reg = v;
		rd_pos = '0;
		wr_pos = '0;
		fill = '0;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic int draw_gap();
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		if ($urandom_range(0, 7) == 0)
			calm_left = $urandom_range(5, 30);
		return $urandom_range(0, 17);
	endfunction

	always @(posedge clk) begin
		out_item_t w;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$error("result with nothing expected: value_out %0d fill_count %0d",
					res.value_out, res.fill_count);
				mismatch_count++;
			end else begin
				w = pending_results.pop_front();
				if (res.value_out !== w.value_out) begin
					$error("value_out: expected %0d, actual %0d", w.value_out, res.value_out);
					mismatch_count++;
				end
				if (res.was_empty !== w.was_empty) begin
					$error("was_empty: expected %0d, actual %0d", w.was_empty, res.was_empty);
					mismatch_count++;
				end
				if (res.dropped_oldest !== w.dropped_oldest) begin
					$error("dropped_oldest: expected %0d, actual %0d",
						w.dropped_oldest, res.dropped_oldest);
					mismatch_count++;
				end
				if (res.fill_count !== w.fill_count) begin
					$error("fill_count: expected %0d, actual %0d", w.fill_count, res.fill_count);
					mismatch_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		int phase_caps [8];
		int push_pct;
		int pick;
		in_item_t it;
		out_item_t none;
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		mismatch_count = 0;
		cycles = 0;
		calm_left = 0;
		none = '0;
		cap_reg = CAP_RESET;
		rd_pos = '0;
		wr_pos = '0;
		fill = '0;
		phase_caps = '{16, 1, 31, 0, 2, 17, -1, -1};

		dir_tab[0]  = mk_row(-1, CMD_POP,     0,       1, -1,     1, 0, 0);
		dir_tab[1]  = mk_row(-1, CMD_MIN,     'h1234,  1, -1,     1, 0, 0);
		dir_tab[2]  = mk_row(-1, CMD_UNKNOWN, 'h7fff,  1, 0,      0, 0, 0);
		dir_tab[3]  = mk_row(-1, CMD_PUSH,    32767,   1, 0,      0, 0, 1);
		dir_tab[4]  = mk_row(-1, CMD_PUSH,    -32768,  1, 0,      0, 0, 2);
		dir_tab[5]  = mk_row(-1, CMD_MIN,     0,       1, -32768, 0, 0, 2);
		dir_tab[6]  = mk_row(-1, CMD_POP,     0,       1, 32767,  0, 0, 1);
		dir_tab[7]  = mk_row(-1, CMD_PUSH,    -1,      0, 0,      0, 0, 0);
		dir_tab[8]  = mk_row(-1, CMD_PUSH,    'h5555,  0, 0,      0, 0, 0);
		dir_tab[9]  = mk_row(-1, CMD_UNKNOWN, -1,      0, 0,      0, 0, 0);
		dir_tab[10] = mk_row(-1, CMD_MIN,     -1,      0, 0,      0, 0, 0);
		dir_tab[11] = mk_row(1,  CMD_PUSH,    100,     1, 0,      0, 0, 1);
		dir_tab[12] = mk_row(-1, CMD_PUSH,    -100,    1, 0,      0, 1, 1);
		dir_tab[13] = mk_row(-1, CMD_MIN,     0,       1, -100,   0, 0, 1);
		dir_tab[14] = mk_row(-1, CMD_POP,     0,       1, -100,   0, 0, 0);
		dir_tab[15] = mk_row(0,  CMD_PUSH,    7,       1, 0,      0, 0, 1);
		dir_tab[16] = mk_row(-1, CMD_PUSH,    8,       1, 0,      0, 1, 1);
		dir_tab[17] = mk_row(2,  CMD_PUSH,    3,       0, 0,      0, 0, 0);
		dir_tab[18] = mk_row(-1, CMD_PUSH,    -2,      0, 0,      0, 0, 0);
		dir_tab[19] = mk_row(-1, CMD_PUSH,    9,       0, 0,      0, 0, 0);
		dir_tab[20] = mk_row(-1, CMD_MIN,     0,       0, 0,      0, 0, 0);
		dir_tab[21] = mk_row(-1, CMD_POP,     0,       0, 0,      0, 0, 0);
		dir_tab[22] = mk_row(31, CMD_PUSH,    -5,      0, 0,      0, 0, 0);
		dir_tab[23] = mk_row(-1, CMD_POP,     0,       0, 0,      0, 0, 0);
		dir_tab[24] = mk_row(-1, CMD_POP,     'haaaa,  0, 0,      0, 0, 0);

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (dir_tab[i]) begin
			if (dir_tab[i].cfg >= 0)
				write_capacity(CFG_W'(dir_tab[i].cfg));
			issue_cmd(dir_tab[i].item, draw_gap(), dir_tab[i].typed, dir_tab[i].want);
		end

		foreach (phase_caps[ph]) begin
			write_capacity(phase_caps[ph] < 0 ? CFG_W'($urandom_range(0, 31))
				: CFG_W'(phase_caps[ph]));
			push_pct = (ph % 2 == 0) ? 60 : 40;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				pick = $urandom_range(0, 99);
				if (pick < push_pct)
					it.command = CMD_PUSH;
				else if (pick < push_pct + (95 - push_pct) / 2)
					it.command = CMD_POP;
				else if (pick < 95)
					it.command = CMD_MIN;
				else
					it.command = CMD_UNKNOWN;
				case ($urandom_range(0, 7))
					0: it.value_in = 16'sh8000;
					1: it.value_in = 16'sh7fff;
					2: it.value_in = -16'sd1;
					3: it.value_in = '0;
					default: it.value_in = 16'($urandom);
				endcase
				// hold off now and then until the block has caught up
				if ($urandom_range(0, 49) == 0)
					drain_results();
				issue_cmd(it, draw_gap(), 1'b0, none);
			end
		end

		drain_results();
		repeat (RING_DEPTH + 4) @(negedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
